[design/hps_pkg.sv]
// Shared constants, types and tables of the heading PID steering block.
package hps_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_BITS     = 24;

  localparam int D_W      = POS_BITS + 1;
  localparam int CX_W     = POS_BITS + 19;
  localparam int Z_W      = 26;
  localparam int TGT_W    = 20;
  localparam int HD_W     = 24;
  localparam int LOOP_N   = CORDIC_STEPS;
  localparam int CNT_W    = $clog2(LOOP_N);
  localparam int DIV_W    = 26;
  localparam int DIV_STEPS = 2;
  localparam int MUL_TERMS = 4;
  localparam int ACC_W    = 64;
  localparam int INT_W    = 48;

  localparam int HD_Q_W   = 16;
  localparam int HD_RSH   = 27;
  localparam int HPROD_W  = HD_W - 3 + 22;
  localparam logic [21:0] HD_RECIP = 22'd2982617;

  localparam int DQ_W     = 19;
  localparam int INC_RSH  = 32;
  localparam int DPROD_W  = DIV_W - 1 + 26;
  localparam logic [25:0] INC_RECIP = 26'd34359739;

  localparam logic signed [Z_W-1:0]   DEG180_Q16 = Z_W'(11796480);
  localparam logic signed [TGT_W-1:0] DEG180_Q8  = TGT_W'(46080);
  localparam logic signed [TGT_W-1:0] DEG360_Q8  = TGT_W'(92160);

  localparam logic [1:0] CFG_P   = 2'd0;
  localparam logic [1:0] CFG_I   = 2'd1;
  localparam logic [1:0] CFG_D   = 2'd2;
  localparam logic [1:0] CFG_LIM = 2'd3;

  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic                  same;
    logic                  reverse;
    logic                  restart;
    logic                  hneg;
    logic [HD_W-1:0]       hmag;
  } hps_item_t;

  typedef struct packed {
    logic signed [15:0] p_gain;
    logic signed [15:0] i_gain;
    logic signed [15:0] d_gain;
    logic [6:0]         turn_limit;
  } hps_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_ANGLE, ST_DIVLD, ST_DIV, ST_INTEG, ST_MUL, ST_OUT
  } hps_state_t;

  function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] i);
    logic [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = Z_W'(2949120);
      5'd1:  v = Z_W'(1740967);
      5'd2:  v = Z_W'(919879);
      5'd3:  v = Z_W'(466945);
      5'd4:  v = Z_W'(234378);
      5'd5:  v = Z_W'(117304);
      5'd6:  v = Z_W'(58666);
      5'd7:  v = Z_W'(29335);
      5'd8:  v = Z_W'(14668);
      5'd9:  v = Z_W'(7334);
      5'd10: v = Z_W'(3667);
      5'd11: v = Z_W'(1833);
      5'd12: v = Z_W'(917);
      5'd13: v = Z_W'(458);
      5'd14: v = Z_W'(229);
      5'd15: v = Z_W'(115);
      5'd16: v = Z_W'(57);
      5'd17: v = Z_W'(29);
      5'd18: v = Z_W'(14);
      5'd19: v = Z_W'(7);
      5'd20: v = Z_W'(4);
      5'd21: v = Z_W'(2);
      5'd22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/hps_front.sv]
// Front end: forms the offset to the goal and splits the heading into whole-degree magnitude and sign.
module hps_front (
  input  logic [hps_pkg::POS_BITS-1:0] goal_x,
  input  logic [hps_pkg::POS_BITS-1:0] goal_y,
  input  logic                         reverse,
  input  logic [hps_pkg::POS_BITS-1:0] pos_x,
  input  logic [hps_pkg::POS_BITS-1:0] pos_y,
  input  logic [31:0]                  heading,
  input  logic                         restart,
  output hps_pkg::hps_item_t           item
);
  logic signed [hps_pkg::D_W-1:0] dx, dy;
  logic signed [32:0]             hd_ext;
  logic [32:0]                    habs;

  assign dx = hps_pkg::D_W'(signed'(goal_x)) - hps_pkg::D_W'(signed'(pos_x));
  assign dy = hps_pkg::D_W'(signed'(goal_y)) - hps_pkg::D_W'(signed'(pos_y));
  assign hd_ext = 33'(signed'(heading));
  assign habs = heading[31] ? 33'(-hd_ext) : 33'(hd_ext);

  always_comb begin
    item.dx      = dx;
    item.dy      = dy;
    item.same    = (dx == '0) && (dy == '0);
    item.reverse = reverse;
    item.restart = restart;
    item.hneg    = heading[31];
    item.hmag    = habs[31:8];
  end
endmodule

[design/hps_queue.sv]
// Two-entry queue between front and back end.
module hps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hps_pkg::hps_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output hps_pkg::hps_item_t rd_item
);
  hps_pkg::hps_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

[design/hps_back.sv]
// The back end of the heading PID steering block is the engine in hps_engine.sv.

[design/hps_engine.sv]
// Back end: iterative CORDIC bearing, heading remainder, PID update and output register.
module hps_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  hps_pkg::hps_cfg_t   cfg,
  input  hps_pkg::hps_item_t  item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_turn,
  output logic [31:0]         out_heading_error,
  output logic                out_clipped
);
  localparam int CX_W  = hps_pkg::CX_W;
  localparam int Z_W   = hps_pkg::Z_W;
  localparam int TGT_W = hps_pkg::TGT_W;
  localparam int CNT_W = hps_pkg::CNT_W;
  localparam int DIV_W = hps_pkg::DIV_W;
  localparam int ACC_W = hps_pkg::ACC_W;
  localparam int INT_W = hps_pkg::INT_W;
  localparam int HD_W  = hps_pkg::HD_W;

  hps_pkg::hps_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    rev_r, rev_nxt, hneg_r, hneg_nxt, same_r, same_nxt;
  logic [HD_W-1:0]         hmag_r, hmag_nxt;
  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic [hps_pkg::HD_Q_W-1:0] hq_r, hq_nxt;
  logic [8:0]              hrem_r, hrem_nxt;
  logic signed [31:0]      err_r, err_nxt, prev_r, prev_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [32:0]      diff_r, diff_nxt;
  logic [DIV_W-1:0]        dreg_r, dreg_nxt;
  logic [hps_pkg::DQ_W-1:0] dquo_r, dquo_nxt;
  logic                    dnz_r, dnz_nxt;
  logic                    dneg_r, dneg_nxt;
  logic signed [48:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ov_r, ov_nxt, oc_r, oc_nxt;
  logic [15:0]             ot_r, ot_nxt;
  logic [31:0]             oe_r, oe_nxt;

  logic signed [CX_W-1:0]  x0, y0;
  logic signed [Z_W-1:0]   z0;
  logic [hps_pkg::HPROD_W-1:0] hprod;
  logic [HD_W-1:0]         hsub;
  logic signed [Z_W-1:0]   zr;
  logic signed [Z_W-9:0]   rq;
  logic signed [TGT_W-1:0] tgt;
  logic signed [10:0]      theta;
  logic signed [32:0]      ssum;
  logic signed [40:0]      nnum;
  logic [40:0]             nabs;
  logic [hps_pkg::DPROD_W-1:0] dprod;
  logic [DIV_W-1:0]        dchk;
  logic signed [INT_W:0]   inc, isum;
  logic signed [15:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [ACC_W-1:0] term;
  logic [CNT_W-1:0]        tix;
  logic signed [ACC_W-1:0] rsum;
  logic signed [INT_W-1:0] tq;
  logic signed [INT_W-1:0] lim;

  assign out_valid         = ov_r;
  assign out_turn          = ot_r;
  assign out_heading_error = oe_r;
  assign out_clipped       = oc_r;

  always_comb begin
    x0 = CX_W'(item.dx) <<< 16;
    y0 = CX_W'(item.dy) <<< 16;
    z0 = '0;
    if (item.dx < 0) begin
      z0 = (item.dy >= 0) ? hps_pkg::DEG180_Q16 : -hps_pkg::DEG180_Q16;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_comb begin
    mul_a = cfg.p_gain;
    mul_b = 33'(err_r);
    unique case (cnt_r)
      CNT_W'(0): begin
        mul_a = cfg.p_gain;
        mul_b = 33'(err_r);
      end
      CNT_W'(1): begin
        mul_a = cfg.d_gain;
        mul_b = diff_r;
      end
      CNT_W'(2): begin
        mul_a = cfg.i_gain;
        mul_b = 33'(signed'({9'd0, integ_r[23:0]}));
      end
      default: begin
        mul_a = cfg.i_gain;
        mul_b = 33'(signed'(integ_r[INT_W-1:24]));
      end
    endcase
  end

  always_comb begin
    tix  = cnt_r - CNT_W'(1);
    term = ACC_W'(prod_r);
    unique case (tix)
      CNT_W'(0), CNT_W'(1): term = ACC_W'(prod_r) <<< 8;
      CNT_W'(2):            term = ACC_W'(prod_r);
      default:              term = ACC_W'(prod_r) <<< 24;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rev_nxt   = rev_r;
    hneg_nxt  = hneg_r;
    same_nxt  = same_r;
    hmag_nxt  = hmag_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    hq_nxt    = hq_r;
    hrem_nxt  = hrem_r;
    err_nxt   = err_r;
    prev_nxt  = prev_r;
    integ_nxt = integ_r;
    diff_nxt  = diff_r;
    dreg_nxt  = dreg_r;
    dquo_nxt  = dquo_r;
    dnz_nxt   = dnz_r;
    dneg_nxt  = dneg_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    ov_nxt    = ov_r && !out_ready;
    ot_nxt    = ot_r;
    oe_nxt    = oe_r;
    oc_nxt    = oc_r;
    q_pop     = 1'b0;
    hprod = '0;
    hsub  = '0;
    zr    = '0;
    rq    = '0;
    tgt   = '0;
    theta = '0;
    ssum  = '0;
    nnum  = '0;
    nabs  = '0;
    dprod = '0;
    dchk  = '0;
    inc   = '0;
    isum  = '0;
    rsum  = '0;
    tq    = '0;
    lim   = '0;
    unique case (state_r)
      hps_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rev_nxt   = item.reverse;
          hneg_nxt  = item.hneg;
          same_nxt  = item.same;
          hmag_nxt  = item.hmag;
          x_nxt     = x0;
          y_nxt     = y0;
          z_nxt     = z0;
          hrem_nxt  = '0;
          cnt_nxt   = '0;
          if (item.restart) begin
            prev_nxt  = '0;
            integ_nxt = '0;
          end
          state_nxt = hps_pkg::ST_CORDIC;
        end
      end
      hps_pkg::ST_CORDIC: begin
        if (y_r > 0) begin
          x_nxt = x_r + (y_r >>> cnt_r);
          y_nxt = y_r - (x_r >>> cnt_r);
          z_nxt = z_r + signed'(hps_pkg::atan_q16(5'(cnt_r)));
        end else begin
          x_nxt = x_r - (y_r >>> cnt_r);
          y_nxt = y_r + (x_r >>> cnt_r);
          z_nxt = z_r - signed'(hps_pkg::atan_q16(5'(cnt_r)));
        end
        if (cnt_r == CNT_W'(0)) begin
          hprod  = hps_pkg::HPROD_W'(hmag_r[HD_W-1:3]) * hps_pkg::HPROD_W'(hps_pkg::HD_RECIP);
          hq_nxt = hprod[hps_pkg::HPROD_W-1:hps_pkg::HD_RSH];
        end
        if (cnt_r == CNT_W'(1)) begin
          hsub     = hmag_r - HD_W'(hq_r) * HD_W'(360);
          hrem_nxt = hsub[8:0];
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(hps_pkg::LOOP_N - 1)) state_nxt = hps_pkg::ST_ANGLE;
      end
      hps_pkg::ST_ANGLE: begin
        zr = z_r + Z_W'(128);
        rq = zr[Z_W-1:8];
        if (same_r) begin
          tgt = '0;
        end else if (TGT_W'(rq) > hps_pkg::DEG180_Q8) begin
          tgt = hps_pkg::DEG180_Q8;
        end else if (TGT_W'(rq) < -hps_pkg::DEG180_Q8) begin
          tgt = -hps_pkg::DEG180_Q8;
        end else begin
          tgt = TGT_W'(rq);
        end
        if (rev_r) tgt = (tgt >= 0) ? tgt - hps_pkg::DEG180_Q8 : tgt + hps_pkg::DEG180_Q8;
        theta = hneg_r ? -signed'({2'b00, hrem_r}) : signed'({2'b00, hrem_r});
        if (theta > 11'sd90 && tgt < 0) begin
          tgt = tgt + hps_pkg::DEG360_Q8;
        end else if (theta < -11'sd90 && tgt > 0) begin
          tgt = tgt - hps_pkg::DEG360_Q8;
        end
        err_nxt   = 32'(tgt) - (32'(theta) <<< 8);
        state_nxt = hps_pkg::ST_DIVLD;
      end
      hps_pkg::ST_DIVLD: begin
        ssum     = 33'(err_r) + 33'(prev_r);
        nnum     = (41'(ssum) <<< 7) + 41'sd125;
        nabs     = nnum[40] ? 41'(-nnum) : 41'(nnum);
        dneg_nxt = nnum[40];
        dreg_nxt = DIV_W'(nabs);
        diff_nxt = 33'(err_r) - 33'(prev_r);
        cnt_nxt  = '0;
        state_nxt = hps_pkg::ST_DIV;
      end
      hps_pkg::ST_DIV: begin
        if (cnt_r == CNT_W'(0)) begin
          dprod    = hps_pkg::DPROD_W'(dreg_r[DIV_W-1:1]) *
                     hps_pkg::DPROD_W'(hps_pkg::INC_RECIP);
          dquo_nxt = dprod[hps_pkg::DPROD_W-1:hps_pkg::INC_RSH];
        end else begin
          dchk    = DIV_W'(dquo_r) * DIV_W'(250);
          dnz_nxt = (dchk != dreg_r);
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(hps_pkg::DIV_STEPS - 1)) state_nxt = hps_pkg::ST_INTEG;
      end
      hps_pkg::ST_INTEG: begin
        inc = signed'((INT_W + 1)'(dquo_r));
        if (dneg_r) inc = -inc - (dnz_r ? 49'sd1 : 49'sd0);
        isum = (INT_W + 1)'(integ_r) + inc;
        if (isum[INT_W] != isum[INT_W-1]) begin
          integ_nxt = isum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
        end else begin
          integ_nxt = isum[INT_W-1:0];
        end
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = hps_pkg::ST_MUL;
      end
      hps_pkg::ST_MUL: begin
        if (cnt_r != '0) acc_nxt = acc_r + term;
        if (32'(cnt_r) < hps_pkg::MUL_TERMS) prod_nxt = mul_a * mul_b;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(hps_pkg::MUL_TERMS)) state_nxt = hps_pkg::ST_OUT;
      end
      hps_pkg::ST_OUT: begin
        if (!ov_r || out_ready) begin
          rsum = acc_r + ACC_W'(32768);
          tq   = rsum[ACC_W-1:16];
          lim  = INT_W'({cfg.turn_limit, 8'd0});
          oc_nxt = 1'b0;
          if (tq > lim) begin
            tq     = lim;
            oc_nxt = 1'b1;
          end else if (tq < -lim) begin
            tq     = -lim;
            oc_nxt = 1'b1;
          end
          ot_nxt    = tq[15:0];
          oe_nxt    = err_r;
          ov_nxt    = 1'b1;
          prev_nxt  = err_r;
          state_nxt = hps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hps_pkg::ST_IDLE;
      cnt_r   <= '0;
      prev_r  <= '0;
      integ_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      integ_r <= integ_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rev_r  <= rev_nxt;
    hneg_r <= hneg_nxt;
    same_r <= same_nxt;
    hmag_r <= hmag_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    hq_r   <= hq_nxt;
    hrem_r <= hrem_nxt;
    err_r  <= err_nxt;
    diff_r <= diff_nxt;
    dreg_r <= dreg_nxt;
    dquo_r <= dquo_nxt;
    dnz_r  <= dnz_nxt;
    dneg_r <= dneg_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    ot_r   <= ot_nxt;
    oe_r   <= oe_nxt;
    oc_r   <= oc_nxt;
  end
endmodule

[design/heading_pid_steering.sv]
// Top level of the heading PID steering block: configuration registers, front, queue, engine.
//
// Input channel (in_valid/in_ready): one beat per control tick carries the goal point,
// current position, accumulated heading (Q24.8 degrees), a reverse flag and a restart flag.
// Output channel (out_valid/out_ready): one beat per input beat with the saturated turn
// command (Q8.8), the heading error (Q24.8 degrees) and a clip flag.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0..3 selects
// p_gain, i_gain, d_gain, turn_limit; write only while the block is idle.
// Engine steps of an item, in order: pick it from the queue, 16 CORDIC iterations
// (the heading remainder by 360 runs in the first two), bearing and error, the
// integral numerator, the reciprocal divide by 250, the integral update, the
// products of the shared 16x33 multiplier summed up, and the output register load.
// The engine works on one item at a time and pops the next only once back in idle.
// The front end and a two-entry queue take new beats while the engine works.
// Reset clears the PID state, the queue and the output valid, and loads the gain
// and limit defaults. When the receiver stalls, the result holds in the output
// register; the engine finishes its next item and waits, and the queue fills and then
// drops in_ready.
module heading_pid_steering (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hps_pkg::POS_BITS-1:0] in_goal_x,
  input  logic [hps_pkg::POS_BITS-1:0] in_goal_y,
  input  logic                         in_reverse,
  input  logic [hps_pkg::POS_BITS-1:0] in_pos_x,
  input  logic [hps_pkg::POS_BITS-1:0] in_pos_y,
  input  logic [31:0]                  in_heading,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_turn,
  output logic [31:0]                  out_heading_error,
  output logic                         out_clipped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  hps_pkg::hps_cfg_t  cfg_r;
  hps_pkg::hps_item_t f_item, q_item;
  logic               q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain     <= -16'sd256;
      cfg_r.i_gain     <= -16'sd256;
      cfg_r.d_gain     <= -16'sd256;
      cfg_r.turn_limit <= 7'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hps_pkg::CFG_P:   cfg_r.p_gain     <= cfg_data;
        hps_pkg::CFG_I:   cfg_r.i_gain     <= cfg_data;
        hps_pkg::CFG_D:   cfg_r.d_gain     <= cfg_data;
        hps_pkg::CFG_LIM: cfg_r.turn_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  hps_front u_front (
    .goal_x  (in_goal_x),
    .goal_y  (in_goal_y),
    .reverse (in_reverse),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .heading (in_heading),
    .restart (in_restart),
    .item    (f_item)
  );

  hps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid && !q_full),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  hps_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .item              (q_item),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_turn          (out_turn),
    .out_heading_error (out_heading_error),
    .out_clipped       (out_clipped)
  );
endmodule

[design/hps_checker.sv]
// Port-level assertions for the heading PID steering block, bound to the top level.
module hps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_turn,
  input logic        out_clipped
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_turn))
    else $error("stalled result beat changed");

  a_clip_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_turn[7:0] == 8'h00)
    else $error("clipped turn is not a whole-unit limit");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_turn) <= 16'sd32512) && ($signed(out_turn) >= -16'sd32512))
    else $error("turn beyond largest limit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");
endmodule

bind heading_pid_steering hps_checker u_hps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_turn    (out_turn),
  .out_clipped (out_clipped)
);

[sim/heading_pid_steering_tb.sv]
// Self-checking testbench of the heading PID steering block with a built-in predictor.
module heading_pid_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = hps_pkg::POS_BITS;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [PB-1:0] goal_x;
    logic [PB-1:0] goal_y;
    logic          reverse;
    logic [PB-1:0] pos_x;
    logic [PB-1:0] pos_y;
    logic [31:0]   heading;
    logic          restart;
  } tick_t;

  typedef struct packed {
    logic [15:0] turn;
    logic [31:0] heading_error;
    logic        clipped;
  } steer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tick_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_turn;
  logic [31:0] out_heading_error;
  logic out_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = hps_pkg::CFG_P;
  logic [15:0] cfg_data = '0;

  tick_t ticks_q[$];
  steer_t steer_expected_q[$];
  int failures = 0;
  int gap_left = 0;
  int hold_left = 0;
  int long_hold_req = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  logic signed [15:0] kp, ki, kd;
  logic [6:0] lim_units;
  longint prev_err, integ;

  always #5 clk = ~clk;

  heading_pid_steering uut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_goal_x(in_item.goal_x), .in_goal_y(in_item.goal_y), .in_reverse(in_item.reverse),
    .in_pos_x(in_item.pos_x), .in_pos_y(in_item.pos_y), .in_heading(in_item.heading),
    .in_restart(in_item.restart),
    .out_valid, .out_ready, .out_turn, .out_heading_error, .out_clipped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, nx, ny, r;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < hps_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z += atan_entry(i);
      end else begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z -= atan_entry(i);
      end
      x = nx;
      y = ny;
    end
    r = shr(z + 128, 8);
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    return r;
  endfunction

  function automatic steer_t steer_predict(tick_t t);
    longint tgt, theta, err, diff, num, inc, sum, turn, lim, q;
    longint imax, imin;
    steer_t r;
    imax = 64'sd140737488355327;
    imin = -imax - 1;
    r.clipped = 1'b0;
    if (t.restart) begin
      prev_err = 0;
      integ = 0;
    end
    tgt = bearing(longint'($signed(t.goal_x)) - longint'($signed(t.pos_x)),
                  longint'($signed(t.goal_y)) - longint'($signed(t.pos_y)));
    if (t.reverse) tgt += (tgt >= 0) ? -46080 : 46080;
    theta = (longint'($signed(t.heading)) / 256) % 360;
    if (theta > 90 && theta < 360 && tgt < 0) tgt += 92160;
    else if (theta < -90 && theta > -360 && tgt > 0) tgt -= 92160;
    err = tgt - theta * 256;
    diff = err - prev_err;
    num = (err + prev_err) * 128 + 125;
    q = num / 250;
    if (num % 250 != 0 && num < 0) q--;
    inc = q;
    integ += inc;
    if (integ > imax) integ = imax;
    if (integ < imin) integ = imin;
    sum = longint'(kp) * err * 256 + longint'(ki) * integ + longint'(kd) * diff * 256;
    turn = shr(sum + 32768, 16);
    prev_err = err;
    lim = longint'(lim_units) * 256;
    if (turn > lim) begin
      turn = lim;
      r.clipped = 1'b1;
    end else if (turn < -lim) begin
      turn = -lim;
      r.clipped = 1'b1;
    end
    r.turn = turn[15:0];
    r.heading_error = err[31:0];
    return r;
  endfunction

  function automatic logic [PB-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(PB-1){1'b1}}};
      1: return {1'b1, {(PB-1){1'b0}}};
      2: return PB'($urandom);
      default: return PB'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.goal_x = rand_pos();
    t.goal_y = rand_pos();
    t.pos_x = ($urandom_range(0, 15) == 0) ? t.goal_x : rand_pos();
    t.pos_y = ($urandom_range(0, 15) == 0) ? t.goal_y : rand_pos();
    if ($urandom_range(0, 9) == 0) t.goal_y = t.pos_y;
    t.reverse = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: t.heading = $urandom;
      default: t.heading = 32'($signed($urandom_range(0, 1000 * 256)) - 500 * 256);
    endcase
    t.restart = ($urandom_range(0, 19) == 0);
    return t;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hps_pkg::CFG_P: kp = val;
      hps_pkg::CFG_I: ki = val;
      hps_pkg::CFG_D: kd = val;
      default: lim_units = val[6:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (ticks_q.size() != 0 || steer_expected_q.size() != 0 || in_valid) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) ticks_q.push_back(rand_tick());
    drain();
  endtask

  task automatic add_tick(logic [PB-1:0] gx, logic [PB-1:0] gy, logic rv,
                          logic [PB-1:0] px, logic [PB-1:0] py, logic [31:0] hd,
                          logic rs);
    tick_t t;
    t = '{gx, gy, rv, px, py, hd, rs};
    ticks_q.push_back(t);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else if (gap_left > 0) begin
      if (in_valid) steer_expected_q.push_back(steer_predict(in_item));
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else begin
      if (in_valid) steer_expected_q.push_back(steer_predict(in_item));
      if (ticks_q.size() != 0) begin
        in_item <= ticks_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    steer_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (steer_expected_q.size() == 0) begin
          $error("unexpected result beat turn=%0h", out_turn);
          failures++;
        end else begin
          e = steer_expected_q.pop_front();
          if (out_turn !== e.turn) begin
            $error("turn expected %0d actual %0d", $signed(e.turn), $signed(out_turn));
            failures++;
          end
          if (out_heading_error !== e.heading_error) begin
            $error("heading_error expected %0d actual %0d",
                   $signed(e.heading_error), $signed(out_heading_error));
            failures++;
          end
          if (out_clipped !== e.clipped) begin
            $error("clipped expected %0b actual %0b", e.clipped, out_clipped);
            failures++;
          end
        end
      end
      if (long_hold_req != 0) begin
        long_hold_req <= 0;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_left <= gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      idle_cycles <= 0;
    end else if (stim_done && steer_expected_q.size() == 0 && !in_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    kp = -256; ki = -256; kd = -256; lim_units = 100;
    prev_err = 0; integ = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_tick(0, 0, 0, 0, 0, 0, 1);
    add_tick(24'h7FFFFF, 24'h7FFFFF, 0, 24'h800000, 24'h800000, 32'h7FFFFFFF, 0);
    add_tick(24'h800000, 24'h800000, 1, 24'h7FFFFF, 24'h7FFFFF, 32'h80000000, 0);
    add_tick(-24'sd50, 0, 0, 0, 0, 32'd0, 0);
    add_tick(-24'sd50, 0, 1, 0, 0, 32'd0, 0);
    add_tick(100, 0, 1, 0, 0, 32'd0, 0);
    add_tick(0, -24'sd100, 0, 0, 0, 32'd180 * 256, 0);
    add_tick(0, 100, 0, 0, 0, -32'sd180 * 256, 0);
    add_tick(0, -24'sd100, 0, 0, 0, 32'd91 * 256, 0);
    add_tick(0, -24'sd100, 0, 0, 0, 32'd90 * 256 + 255, 0);
    add_tick(0, 100, 0, 0, 0, -32'sd91 * 256, 0);
    add_tick(0, 100, 0, 0, 0, -32'sd90 * 256 - 255, 0);
    add_tick(0, -24'sd100, 0, 0, 0, 32'd359 * 256, 0);
    add_tick(0, -24'sd100, 0, 0, 0, 32'd720 * 256 + 17, 0);
    add_tick(0, 100, 0, 0, 0, -32'sd719 * 256, 1);
    add_tick(3, 4, 0, 0, 0, 32'd45 * 256, 0);
    drain();

    cfg_write(hps_pkg::CFG_LIM, 16'd0);
    add_tick(0, 100, 0, 0, 0, 0, 1);
    add_tick(0, 0, 0, 0, 0, 0, 0);
    add_tick(0, 0, 0, 0, 0, 0, 1);
    drain();
    cfg_write(hps_pkg::CFG_P, 16'h0100);
    cfg_write(hps_pkg::CFG_I, 16'h0000);
    cfg_write(hps_pkg::CFG_D, 16'h0000);
    cfg_write(hps_pkg::CFG_LIM, 16'd127);
    add_tick(0, 0, 0, 0, 0, -32'sd127 * 256, 1);
    add_tick(0, 0, 0, 0, 0, -32'sd128 * 256, 0);
    drain();

    cfg_write(hps_pkg::CFG_LIM, 16'd127);
    cfg_write(hps_pkg::CFG_P, 16'h7FFF);
    cfg_write(hps_pkg::CFG_I, 16'h8000);
    cfg_write(hps_pkg::CFG_D, 16'h7FFF);
    run_phase(150);
    cfg_write(hps_pkg::CFG_P, 16'h8000);
    cfg_write(hps_pkg::CFG_I, 16'h7FFF);
    cfg_write(hps_pkg::CFG_D, 16'h8000);
    cfg_write(hps_pkg::CFG_LIM, 16'd0);
    run_phase(100);
    for (int k = 0; k < 5; k++) begin
      cfg_write(hps_pkg::CFG_P, 16'($urandom_range(0, 1023)) - 16'd512);
      cfg_write(hps_pkg::CFG_I, 16'($urandom));
      cfg_write(hps_pkg::CFG_D, 16'($urandom_range(0, 255)) - 16'd128);
      cfg_write(hps_pkg::CFG_LIM, 16'($urandom_range(1, 127)));
      if (k == 2) long_hold_req = 1;
      run_phase(200);
    end
    cfg_write(hps_pkg::CFG_P, 16'hFF00);
    cfg_write(hps_pkg::CFG_I, 16'hFF00);
    cfg_write(hps_pkg::CFG_D, 16'hFF00);
    cfg_write(hps_pkg::CFG_LIM, 16'd100);
    run_phase(50);

    stim_done = 1'b1;
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[heading_pid_steering.f]
design/hps_pkg.sv
design/hps_front.sv
design/hps_queue.sv
design/hps_back.sv
design/hps_engine.sv
design/heading_pid_steering.sv
design/hps_checker.sv
sim/heading_pid_steering_tb.sv
